/* hdl/alrl_pkg.sv */
// ----------------------------------------------------------------------------
// alrl_pkg: shared types and constants of the attempt lockout rate limiter
// Table entry layout, operation codes, register indexes, port widths and
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package alrl_pkg;

  // Table geometry
  localparam int DEF_TABLE_ENTRIES = 256;

  // Port widths
  localparam int IDX_IN_W    = 8;
  localparam int TIME_W      = 64;
  localparam int TALLY_W     = 8;
  localparam int IN_TDATA_W  = 72;   // client_index + now_ms, whole bytes
  localparam int IN_TUSER_W  = 2;    // func
  localparam int OUT_TDATA_W = 8;    // allowed, locked, zero fill
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int LIMIT_W     = 8;
  localparam int SEC_W       = 16;
  localparam int MS_W        = 26;   // 65535 s * 1000 fits in 26 bits

  localparam logic [9:0]         MS_PER_SEC = 10'd1000;
  localparam logic [TALLY_W-1:0] TALLY_MAX  = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 4'd3;

  // Register reset values
  localparam logic               RST_ENABLE  = 1'b1;
  localparam logic [LIMIT_W-1:0] RST_LIMIT   = 8'd5;
  localparam logic [SEC_W-1:0]   RST_WINDOW  = 16'd120;
  localparam logic [SEC_W-1:0]   RST_LOCKOUT = 16'd120;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_RECORD = 2'd1,
    OP_FORGET = 2'd2,
    OP_QUERY  = 2'd3
  } func_t;

  // One table slot, as stored in the entry RAM
  typedef struct packed {
    logic               valid;
    logic               locked;
    logic [TALLY_W-1:0] tally;
    logic [TIME_W-1:0]  win_start;
    logic [TIME_W-1:0]  lock_start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller -> datapath commands
  typedef struct packed {
    logic clr_wr;    // clear one slot, advance sweep counter
    logic ld_item;   // latch input word, launch slot read
    logic eval;      // register slot and expiry compares
    logic commit;    // write slot back, load result
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clr_last;  // sweep is on the last slot
    logic out_full;  // result register cannot take a new word
  } dp_stat_t;

endpackage

/* hdl/alrl_ram.sv */
// ----------------------------------------------------------------------------
// alrl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/alrl_ctrl.sv */
// ----------------------------------------------------------------------------
// alrl_ctrl: sequencer of the rate limiter
// Runs the clearing sweep after reset, then walks each word through
// read, evaluate and commit of its table slot.
// ----------------------------------------------------------------------------
module alrl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output alrl_pkg::ctrl_cmd_t cmd,
  input  alrl_pkg::dp_stat_t  stat
);

  import alrl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r, in_rdy_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_rdy_nxt = in_rdy_r;
    cmd        = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt  = ST_IDLE;
          in_rdy_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_rdy_r && in_tvalid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = ST_EVAL;
          in_rdy_nxt  = 1'b0;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the result register can take the word
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
          in_rdy_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt  = ST_CLEAR;
        in_rdy_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      in_rdy_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_rdy_r <= in_rdy_nxt;
    end
  end

  assign in_tready = in_rdy_r;

  a_ld_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_item |=> cmd.eval)
    else $error("slot read not followed by evaluate");

  a_commit_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (in_tready && !cmd.eval && !cmd.commit))
    else $error("input not reopened after commit");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_tready)
    else $error("input open during clearing sweep");

endmodule

/* hdl/alrl_dp.sv */
// ----------------------------------------------------------------------------
// alrl_dp: datapath of the rate limiter
// Slot index reduction, entry RAM, expiry compares, entry update rules,
// clearing sweep counter and the result register.
// ----------------------------------------------------------------------------
module alrl_dp #(
  parameter int TABLE_ENTRIES = alrl_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alrl_pkg::ctrl_cmd_t           cmd,
  output alrl_pkg::dp_stat_t            stat,
  input  alrl_pkg::func_t               in_func,
  input  logic [alrl_pkg::IDX_IN_W-1:0] in_client,
  input  logic [alrl_pkg::TIME_W-1:0]   in_now,
  input  logic                          cfg_enable,
  input  logic [alrl_pkg::LIMIT_W-1:0]  cfg_limit,
  input  logic [alrl_pkg::MS_W-1:0]     win_ms,
  input  logic [alrl_pkg::MS_W-1:0]     lock_ms,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic                          out_allowed,
  output logic                          out_locked
);

  import alrl_pkg::*;

  localparam int                 IDX_W    = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W:0]     N_SLOTS  = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // client_index modulo the table size, one restoring step per input bit
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_IN_W-1:0] v);
    logic [IDX_W:0] rem;
    rem = '0;
    for (int i = IDX_IN_W - 1; i >= 0; i--) begin
      rem = {rem[IDX_W-1:0], v[i]};
      if (rem >= N_SLOTS) begin
        rem = rem - N_SLOTS;
      end
    end
    return rem[IDX_W-1:0];
  endfunction

  func_t             op_r;
  logic [IDX_W-1:0]  slot_r;
  logic [TIME_W-1:0] now_r;
  entry_t            entry_r;
  logic              win_exp_r;
  logic              lock_exp_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic              out_valid_r;
  logic              allowed_r;
  logic              locked_r;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              res_allowed;
  logic              res_locked;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_IN_W-1:0] in_slot_src;

  assign in_slot_src = in_client;

  alrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ld_item),
    .raddr (slot_of(in_slot_src)),
    .rdata (rd_entry)
  );

  // Latch the word and the elapsed-time compares
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      op_r   <= in_func;
      slot_r <= slot_of(in_slot_src);
      now_r  <= in_now;
    end
    if (cmd.eval) begin
      entry_r    <= rd_entry;
      win_exp_r  <= (now_r - rd_entry.win_start) > {{(TIME_W - MS_W){1'b0}}, win_ms};
      lock_exp_r <= (now_r - rd_entry.lock_start) > {{(TIME_W - MS_W){1'b0}}, lock_ms};
    end
  end

  // Entry update rules
  always_comb begin
    wr_entry    = entry_r;
    res_allowed = 1'b0;
    res_locked  = 1'b0;
    case (op_r)
      OP_CHECK: begin
        if (!cfg_enable || !entry_r.valid) begin
          res_allowed = 1'b1;
        end else if (entry_r.locked) begin
          if (lock_exp_r) begin
            wr_entry.locked    = 1'b0;
            wr_entry.tally     = '0;
            wr_entry.win_start = now_r;
            res_allowed        = 1'b1;
          end
        end else if (win_exp_r) begin
          wr_entry.tally     = '0;
          wr_entry.win_start = now_r;
          res_allowed        = 1'b1;
        end else begin
          res_allowed = (entry_r.tally < cfg_limit);
        end
      end
      OP_RECORD: begin
        if (cfg_enable) begin
          if (!entry_r.valid) begin
            // fresh slot: its window starts now and cannot be expired
            wr_entry.valid      = 1'b1;
            wr_entry.locked     = 1'b0;
            wr_entry.tally      = '0;
            wr_entry.win_start  = now_r;
            wr_entry.lock_start = '0;
          end else if (win_exp_r) begin
            wr_entry.tally     = '0;
            wr_entry.win_start = now_r;
          end
          if (wr_entry.tally != TALLY_MAX) begin
            wr_entry.tally = wr_entry.tally + TALLY_W'(1);
          end
          if (wr_entry.tally > cfg_limit) begin
            wr_entry.locked     = 1'b1;
            wr_entry.lock_start = now_r;
          end
        end
      end
      OP_FORGET: begin
        wr_entry.valid = 1'b0;
      end
      OP_QUERY: begin
        res_locked = entry_r.valid && entry_r.locked && !lock_exp_r;
      end
      default: begin
        wr_entry = entry_r;
      end
    endcase
  end

  // RAM write: sweep during clear, write back on commit
  assign ram_we    = cmd.clr_wr | cmd.commit;
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : slot_r;
  assign ram_wdata = cmd.clr_wr ? entry_t'('0) : wr_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      allowed_r <= res_allowed;
      locked_r  <= res_locked;
    end
  end

  assign stat.clr_last = (clr_cnt_r == LAST_IDX);
  assign stat.out_full = out_valid_r & ~out_tready;

  assign out_valid   = out_valid_r;
  assign out_allowed = allowed_r;
  assign out_locked  = locked_r;

  a_one_result_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(allowed_r && locked_r))
    else $error("allowed and locked both set");

  a_record_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_RECORD && cfg_enable) |->
      (wr_entry.valid && wr_entry.tally != '0))
    else $error("enabled record left slot empty or tally zero");

  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

/* hdl/attempt_lockout_rate_limiter_top.sv */
// ----------------------------------------------------------------------------
// attempt_lockout_rate_limiter_top: per-client login attempt limiter
// Fixed-window attempt counting with lockout, kept in a slot table.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (in_*): one word per operation. in_tuser carries func
//    (check, record, forget, query); in_tdata carries client_index and
//    now_ms. The slot is client_index modulo TABLE_ENTRIES.
//  - Output stream (out_*): exactly one word per input word, in order.
//    allowed answers a check, locked answers a query; both read 0 otherwise.
//  - Config port (cfg_*): always ready; index 0 enable, 1 attempt limit,
//    2 window seconds, 3 lockout seconds. Other indexes are dropped. Write
//    only while no word is in flight.
//  - Sequence: the sequencer reads the slot of an accepted word, compares
//    both elapsed times, then writes the slot back through one RAM and loads
//    the result; it takes no new word until the last one is written back.
//  - Reset: registers take their defaults, then a clearing sweep writes
//    every slot empty; in_tready stays low meanwhile (config writes are
//    still taken).
//  - Stall: a result waiting on out_tready holds in the output register;
//    the next word is still accepted and read, and its write back holds
//    until the output register frees up.
// ----------------------------------------------------------------------------
module attempt_lockout_rate_limiter_top #(
  parameter int TABLE_ENTRIES = alrl_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] client_index, [71:8] now_ms
  input  logic [alrl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: [1:0] func
  input  logic [alrl_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: [0] allowed, [1] locked, [7:2] zero
  output logic [alrl_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alrl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import alrl_pkg::*;

  logic               cfg_enable_r;
  logic [LIMIT_W-1:0] cfg_limit_r;
  logic [SEC_W-1:0]   cfg_window_r;
  logic [SEC_W-1:0]   cfg_lockout_r;
  logic [MS_W-1:0]    win_ms_r, win_ms_nxt;
  logic [MS_W-1:0]    lock_ms_r, lock_ms_nxt;

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic               res_allowed;
  logic               res_locked;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r  <= RST_ENABLE;
      cfg_limit_r   <= RST_LIMIT;
      cfg_window_r  <= RST_WINDOW;
      cfg_lockout_r <= RST_LOCKOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:  cfg_enable_r  <= cfg_data[0];
        CFG_LIMIT:   cfg_limit_r   <= cfg_data[LIMIT_W-1:0];
        CFG_WINDOW:  cfg_window_r  <= cfg_data[SEC_W-1:0];
        CFG_LOCKOUT: cfg_lockout_r <= cfg_data[SEC_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Lengths in milliseconds, registered so the compare stage sees no multiply
  assign win_ms_nxt  = MS_W'(cfg_window_r) * MS_W'(MS_PER_SEC);
  assign lock_ms_nxt = MS_W'(cfg_lockout_r) * MS_W'(MS_PER_SEC);

  always_ff @(posedge clk) begin
    win_ms_r  <= win_ms_nxt;
    lock_ms_r <= lock_ms_nxt;
  end

  alrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  alrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (func_t'(in_tuser)),
    .in_client   (in_tdata[IDX_IN_W-1:0]),
    .in_now      (in_tdata[IDX_IN_W +: TIME_W]),
    .cfg_enable  (cfg_enable_r),
    .cfg_limit   (cfg_limit_r),
    .win_ms      (win_ms_r),
    .lock_ms     (lock_ms_r),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_allowed (res_allowed),
    .out_locked  (res_locked)
  );

  assign out_tdata = {{(OUT_TDATA_W - 2){1'b0}}, res_locked, res_allowed};

endmodule

/* test/tb_attempt_lockout_rate_limiter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_attempt_lockout_rate_limiter_top: self-checking bench of the limiter
// Streams check, record, forget and query words into the block and compares
// every result word against a cycle-free model of the client slot table.
// Several register settings are swept between drained phases. Random idle
// bursts are applied on both streams.
// ----------------------------------------------------------------------------
module tb_attempt_lockout_rate_limiter_top;
  import alrl_pkg::*;

  localparam int unsigned    CYCLE_LIMIT = 300000;
  localparam logic [63:0]    MS_PER_S    = 64'd1000;
  // Indexes past the register list; the block must drop writes to them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_LOCKOUT + 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  // One operation word as it travels on the input stream
  typedef struct packed {
    func_t       op;
    logic [7:0]  slot;
    logic [63:0] now;
  } attempt_t;

  // One result word: out_tdata[0] allowed, out_tdata[1] locked
  typedef struct packed {
    logic locked;
    logic allowed;
  } verdict_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  attempt_t    pending_q[$];  // words waiting for the driver
  verdict_t    verdict_q[$];  // results owed by the block, oldest first
  int unsigned in_gap      = 0;
  int unsigned out_gap     = 0;
  bit          calm        = 1'b0;  // set: no idling on either stream
  int unsigned n_fail      = 0;
  int unsigned cycle_count = 0;
  logic [63:0] wall_ms     = '0;   // running time base of the stimulus

  // Model state: limiter registers and the client slot table
  bit          lim_en;
  logic [7:0]  lim_max;
  logic [15:0] win_sec;
  logic [15:0] lock_sec;
  bit          ent_valid  [DEF_TABLE_ENTRIES];
  bit          ent_locked [DEF_TABLE_ENTRIES];
  logic [7:0]  ent_tally  [DEF_TABLE_ENTRIES];
  logic [63:0] ent_win    [DEF_TABLE_ENTRIES];
  logic [63:0] ent_lock   [DEF_TABLE_ENTRIES];

  attempt_lockout_rate_limiter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Slot table model
  // --------------------------------------------------------------------------

  // Elapsed time wraps modulo 2^64; a span expires only when strictly longer
  // than its length in milliseconds.
  function automatic bit aged_out(logic [63:0] now, logic [63:0] start,
                                  logic [15:0] sec);
    logic [63:0] span;
    span = now - start;
    return span > (64'(sec) * MS_PER_S);
  endfunction

  function automatic void set_limiter_reg(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ENABLE:  lim_en   = val[0];
      CFG_LIMIT:   lim_max  = val[7:0];
      CFG_WINDOW:  win_sec  = val;
      CFG_LOCKOUT: lock_sec = val;
      default: ;
    endcase
  endfunction

  // Apply one operation to the table and return the word the block owes.
  function automatic verdict_t limiter_step(func_t op, logic [7:0] slot,
                                            logic [63:0] now);
    verdict_t v;
    v = '0;
    case (op)
      OP_CHECK: begin
        if (!lim_en || !ent_valid[slot]) begin
          v.allowed = 1'b1;
        end else if (ent_locked[slot]) begin
          // An expired lockout opens a fresh window; a live one denies
          if (aged_out(now, ent_lock[slot], lock_sec)) begin
            ent_locked[slot] = 1'b0;
            ent_tally[slot]  = '0;
            ent_win[slot]    = now;
            v.allowed        = 1'b1;
          end
        end else if (aged_out(now, ent_win[slot], win_sec)) begin
          ent_tally[slot] = '0;
          ent_win[slot]   = now;
          v.allowed       = 1'b1;
        end else begin
          v.allowed = (ent_tally[slot] < lim_max);
        end
      end
      OP_RECORD: begin
        if (lim_en) begin
          if (!ent_valid[slot]) begin
            ent_valid[slot]  = 1'b1;
            ent_locked[slot] = 1'b0;
            ent_tally[slot]  = '0;
            ent_win[slot]    = now;
            ent_lock[slot]   = '0;
          end
          if (aged_out(now, ent_win[slot], win_sec)) begin
            ent_tally[slot] = '0;
            ent_win[slot]   = now;
          end
          // Saturate the tally; a record never looks at a live lockout
          if (ent_tally[slot] != TALLY_MAX) ent_tally[slot] = ent_tally[slot] + 8'd1;
          if (ent_tally[slot] > lim_max) begin
            ent_locked[slot] = 1'b1;
            ent_lock[slot]   = now;
          end
        end
      end
      OP_FORGET: ent_valid[slot] = 1'b0;
      OP_QUERY: begin
        v.locked = ent_valid[slot] && ent_locked[slot] &&
                   !aged_out(now, ent_lock[slot], lock_sec);
      end
      default: ;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: present queued words, hold each until taken, and open
  // random idle bursts between words.
  // The model advances on each accepted word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    attempt_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(limiter_step(func_t'(in_tuser), in_tdata[IDX_IN_W-1:0],
                                         in_tdata[IN_TDATA_W-1:IDX_IN_W]));
      end
      // A word still waiting for in_tready keeps its place
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap    <= $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt       = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.now, nxt.slot};
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: stall out_tready in random bursts and compare every
  // result word with the oldest owed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word %h with no result owed", out_tdata);
          n_fail++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.allowed) begin
            $error("allowed: expected %0b, actual %0b", want.allowed, out_tdata[0]);
            n_fail++;
          end
          if (out_tdata[1] !== want.locked) begin
            $error("locked: expected %0b, actual %0b", want.locked, out_tdata[1]);
            n_fail++;
          end
          if (out_tdata[OUT_TDATA_W-1:2] !== '0) begin
            $error("zero fill: expected 0, actual %h", out_tdata[OUT_TDATA_W-1:2]);
            n_fail++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap    <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("attempt_lockout_rate_limiter_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Keep the driver queue short so that times aimed at a slot's expiry edge
  // are computed from nearly current table contents.
  task automatic make_room();
    @(negedge clk);
    while (pending_q.size() >= 2) @(negedge clk);
  endtask

  task automatic send(input func_t op, input logic [7:0] slot, input logic [63:0] now);
    make_room();
    pending_q.push_back('{op, slot, now});
  endtask

  // Wait until every word is taken and every owed result has come back
  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_limiter_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a handful of busy slots so that tallies build up; the rest spread
  // over the whole table.
  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic func_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_CHECK;
    if (r < 70) return OP_RECORD;
    if (r < 80) return OP_FORGET;
    return OP_QUERY;
  endfunction

  // Choose the time of the next word: hold, creep, jump onto a slot's window
  // or lockout edge (one below, on, one past), leap past whole spans, go
  // fully random, or park just below the wrap point.
  function automatic logic [63:0] next_time(logic [7:0] slot);
    int unsigned mode;
    logic [63:0] edge_ms;
    mode = $urandom_range(0, 99);
    if (mode < 20) begin
      // hold the time base
    end else if (mode >= 50 && mode < 75 && ent_valid[slot]) begin
      if (ent_locked[slot] && $urandom_range(0, 1) == 1)
        edge_ms = ent_lock[slot] + 64'(lock_sec) * MS_PER_S;
      else
        edge_ms = ent_win[slot] + 64'(win_sec) * MS_PER_S;
      wall_ms = edge_ms + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (mode >= 75 && mode < 90) begin
      wall_ms = wall_ms + 64'($urandom_range(0, 32'(win_sec) * 32'd1000 +
                                              32'(lock_sec) * 32'd1000 + 32'd2));
    end else if (mode >= 90 && mode < 96) begin
      wall_ms = {$urandom, $urandom};
    end else if (mode >= 96) begin
      wall_ms = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3000));
    end else begin
      wall_ms = wall_ms + 64'($urandom_range(0, 2000));
    end
    return wall_ms;
  endfunction

  // Random traffic: about a third are runs that hammer one slot with records,
  // often past its limit, and then ask about it; the rest are single random words.
  task automatic roll_attempts(input int unsigned total);
    int unsigned made;
    int unsigned burst;
    logic [7:0]  slot;
    func_t       op;
    made = 0;
    while (made < total) begin
      if ($urandom_range(0, 99) < 30) begin
        slot  = pick_slot();
        burst = $urandom_range(1, 12);
        for (int unsigned k = 0; k < burst; k++) begin
          make_room();
          wall_ms = wall_ms + 64'($urandom_range(0, 40));
          pending_q.push_back('{OP_RECORD, slot, wall_ms});
        end
        make_room();
        pending_q.push_back('{OP_CHECK, slot, next_time(slot)});
        make_room();
        pending_q.push_back('{OP_QUERY, slot, next_time(slot)});
        made += burst + 2;
      end else begin
        make_room();
        slot = pick_slot();
        op   = pick_op();
        pending_q.push_back('{op, slot, next_time(slot)});
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_proc
    logic [63:0] t0;
    logic [63:0] t_sat;

    lim_en   = RST_ENABLE;
    lim_max  = RST_LIMIT;
    win_sec  = RST_WINDOW;
    lock_sec = RST_LOCKOUT;
    for (int i = 0; i < DEF_TABLE_ENTRIES; i++) begin
      ent_valid[i]  = 1'b0;
      ent_locked[i] = 1'b0;
      ent_tally[i]  = '0;
      ent_win[i]    = '0;
      ent_lock[i]   = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (limit 5, 120 s window and lockout)
    send(OP_CHECK, 8'h00, 64'd0);                 // empty slot passes
    send(OP_QUERY, 8'hFF, 64'd0);                 // empty slot is not locked
    // Six records lock the slot just below the wrap point
    t0 = 64'hFFFF_FFFF_FFFF_FFF0;
    repeat (6) send(OP_RECORD, 8'hFF, t0);
    send(OP_CHECK, 8'hFF, t0);
    send(OP_QUERY, 8'hFF, t0);
    // Exactly on the lockout length it still holds; one past, it expires
    send(OP_QUERY, 8'hFF, t0 + 64'd120000);
    send(OP_CHECK, 8'hFF, t0 + 64'd120000);
    send(OP_QUERY, 8'hFF, t0 + 64'd120001);
    send(OP_CHECK, 8'hFF, t0 + 64'd120001);
    // Window edge: on the length it counts on, one past it restarts
    send(OP_RECORD, 8'h00, 64'd0);
    send(OP_RECORD, 8'h00, 64'd120000);
    send(OP_RECORD, 8'h00, 64'd120001);
    send(OP_CHECK, 8'h00, 64'd120001);
    // Forget drops the slot
    send(OP_FORGET, 8'hFF, 64'd5);
    send(OP_QUERY, 8'hFF, 64'd5);
    send(OP_CHECK, 8'hFF, 64'd5);
    // A time jump that wraps backwards reads as a huge elapsed span
    send(OP_RECORD, 8'hAA, 64'h5555_5555_5555_5555);
    send(OP_CHECK, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send(OP_QUERY, 8'hAA, 64'd0);
    settle();

    // Lowest settings: limit 0, zero-length window and lockout
    wall_ms = {$urandom, $urandom};
    write_reg(CFG_ENABLE, 16'h0001);
    write_reg(CFG_LIMIT, 16'h0000);
    write_reg(CFG_WINDOW, 16'h0000);
    write_reg(CFG_LOCKOUT, 16'h0000);
    roll_attempts(120);
    settle();

    // Short spans; pause mid-phase until the block has answered everything
    write_reg(CFG_LIMIT, 16'd2);
    write_reg(CFG_WINDOW, 16'd3);
    write_reg(CFG_LOCKOUT, 16'd5);
    roll_attempts(100);
    settle();
    roll_attempts(100);
    settle();

    // Disabled: check passes, record is dropped, forget and query still act.
    // Only bit 0 of the data counts.
    write_reg(CFG_ENABLE, 16'hFFFE);
    roll_attempts(100);
    settle();

    // Saturation: a limit of 255 (upper data bits masked) never locks, and
    // the tally sticks at 255; longest spans keep the window open.
    write_reg(CFG_ENABLE, 16'h8001);
    write_reg(CFG_LIMIT, 16'h01FF);
    write_reg(CFG_WINDOW, 16'hFFFF);
    write_reg(CFG_LOCKOUT, 16'hFFFF);
    t_sat = {$urandom, $urandom};
    repeat (256) send(OP_RECORD, 8'h5A, t_sat);
    send(OP_CHECK, 8'h5A, t_sat);
    send(OP_QUERY, 8'h5A, t_sat);
    settle();
    // Limit 254: the saturated tally now locks on the next record
    write_reg(CFG_LIMIT, 16'hFEFE);
    send(OP_RECORD, 8'h5A, t_sat);
    send(OP_CHECK, 8'h5A, t_sat + 64'd65535000);
    send(OP_QUERY, 8'h5A, t_sat + 64'd65535000);
    settle();

    // Tight spans, then writes past the register list that must be dropped
    write_reg(CFG_LIMIT, 16'd1);
    write_reg(CFG_WINDOW, 16'd1);
    write_reg(CFG_LOCKOUT, 16'd2);
    write_reg(CFG_UNUSED_LO, 16'h0000);
    write_reg(CFG_UNUSED_HI, 16'h0000);
    roll_attempts(200);
    settle();

    // Back to ordinary settings; the tail runs without idling
    write_reg(CFG_LIMIT, 16'd5);
    write_reg(CFG_WINDOW, 16'd120);
    write_reg(CFG_LOCKOUT, 16'd120);
    roll_attempts(50);
    calm = 1'b1;
    roll_attempts(100);
    settle();

    // Let any stray word surface before the verdict
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("attempt_lockout_rate_limiter_top verification clean");
    end else begin
      $display("attempt_lockout_rate_limiter_top verification failed");
    end
    $finish;
  end

endmodule
